### sv/dxt3_block_decoder_defines.svh
// assertion helpers for the dxt3 block decoder
// every macro samples on clk and is off while arst_n is low
`ifndef DXT3_BLOCK_DECODER_DEFINES_SVH
`define DXT3_BLOCK_DECODER_DEFINES_SVH

// same-cycle implication
`define DXT3_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dxt3 same-cycle check failed");

// next-cycle implication
`define DXT3_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dxt3 next-cycle check failed");

`endif

### sv/dxt3_pkg.sv
`default_nettype none

package dxt3_pkg;

	localparam int unsigned ROWS_PER_BLOCK = 4;

	// reciprocals for exact truncating division over the value ranges used
	localparam logic [13:0] RECIP31 = 14'd8457;   // 2^18 / 31, rounded up
	localparam logic [14:0] RECIP63 = 15'd16645;  // 2^20 / 63, rounded up
	localparam logic [10:0] RECIP3  = 11'd1366;   // 2^12 / 3, rounded up

	typedef logic [23:0] rgb_t;  // red low byte, blue high byte

	typedef struct packed {
		rgb_t [3:0]  colour;
		logic [63:0] alphas;
		logic [31:0] indices;
	} pal_t;

	// x*255/31, truncated
	function automatic logic [7:0] expand5(input logic [4:0] x);
		logic [12:0] v;
		logic [26:0] p;
		v = {x, 8'b0} - {8'b0, x};
		p = 27'(v) * 27'(RECIP31);
		return p[25:18];
	endfunction

	// x*255/63, truncated
	function automatic logic [7:0] expand6(input logic [5:0] x);
		logic [13:0] v;
		logic [28:0] p;
		v = {x, 8'b0} - {8'b0, x};
		p = 29'(v) * 29'(RECIP63);
		return p[27:20];
	endfunction

	function automatic rgb_t expand565(input logic [15:0] e);
		return {expand5(e[4:0]), expand6(e[10:5]), expand5(e[15:11])};
	endfunction

	// (2h+l)/3 on one channel, truncated
	function automatic logic [7:0] blend_ch(input logic [7:0] h, input logic [7:0] l);
		logic [9:0]  s;
		logic [20:0] p;
		s = {1'b0, h, 1'b0} + {2'b0, l};
		p = 21'(s) * 21'(RECIP3);
		return p[19:12];
	endfunction

	function automatic rgb_t blend(input rgb_t h, input rgb_t l);
		return {blend_ch(h[23:16], l[23:16]), blend_ch(h[15:8], l[15:8]),
			blend_ch(h[7:0], l[7:0])};
	endfunction

endpackage

`default_nettype wire

### sv/dxt3_if.sv
`default_nettype none

interface dxt3_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] alpha_bits;
	logic [15:0] endpoint_a;
	logic [15:0] endpoint_b;
	logic [31:0] pixel_indices;

	modport source (output valid, alpha_bits, endpoint_a, endpoint_b, pixel_indices,
		input ready);
	modport sink (input valid, alpha_bits, endpoint_a, endpoint_b, pixel_indices,
		output ready);
endinterface

interface dxt3_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  row_number;
	logic [31:0] pixel_col0;
	logic [31:0] pixel_col1;
	logic [31:0] pixel_col2;
	logic [31:0] pixel_col3;
	logic        last_row;

	modport source (output valid, row_number, pixel_col0, pixel_col1, pixel_col2,
		pixel_col3, last_row, input ready);
	modport sink (input valid, row_number, pixel_col0, pixel_col1, pixel_col2,
		pixel_col3, last_row, output ready);
endinterface

`default_nettype wire

### sv/dxt3_palette.sv
`default_nettype none

module dxt3_palette (
	input  wire logic          clk,
	input  wire logic          arst_n,
	dxt3_in_if.sink            blocks,
	output logic               pal_valid,
	input  wire logic          pal_ready,
	output dxt3_pkg::pal_t     pal
);
	import dxt3_pkg::*;

	logic        v_s1, v_s2;
	logic        ready_s1, ready_s2;
	rgb_t        ca_s1, cb_s1;
	logic [63:0] alphas_s1;
	logic [31:0] indices_s1;
	pal_t        pal_s2;

	assign ready_s2     = !v_s2 || pal_ready;
	assign ready_s1     = !v_s1 || ready_s2;
	assign blocks.ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (ready_s1) v_s1 <= blocks.valid;
			if (ready_s2) v_s2 <= v_s1;
		end
	end

	// stage 1: endpoint expansion
	always_ff @(posedge clk) begin
		if (ready_s1 && blocks.valid) begin
			ca_s1      <= expand565(blocks.endpoint_a);
			cb_s1      <= expand565(blocks.endpoint_b);
			alphas_s1  <= blocks.alpha_bits;
			indices_s1 <= blocks.pixel_indices;
		end
	end

	// stage 2: the two interpolated colours
	always_ff @(posedge clk) begin
		if (ready_s2 && v_s1) begin
			pal_s2.colour[0] <= ca_s1;
			pal_s2.colour[1] <= cb_s1;
			pal_s2.colour[2] <= blend(ca_s1, cb_s1);
			pal_s2.colour[3] <= blend(cb_s1, ca_s1);
			pal_s2.alphas    <= alphas_s1;
			pal_s2.indices   <= indices_s1;
		end
	end

	assign pal_valid = v_s2;
	assign pal       = pal_s2;

endmodule

`default_nettype wire

### sv/dxt3_row_seq.sv
`default_nettype none
`include "dxt3_block_decoder_defines.svh"

module dxt3_row_seq (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          pal_valid,
	output logic               pal_ready,
	input  wire dxt3_pkg::pal_t pal,
	dxt3_out_if.source         rows
);
	import dxt3_pkg::*;

	logic        v_s3, v_s4;
	pal_t        pal_s3;
	logic [1:0]  row_q;
	logic        feed;
	logic        last_beat;
	logic [7:0]  row_idx;
	logic [15:0] row_alpha;
	logic [3:0][31:0] px;

	logic [1:0]       row_s4;
	logic [3:0][31:0] px_s4;
	logic             last_s4;

	assign feed      = v_s3 && (!v_s4 || rows.ready);
	assign last_beat = (row_q == 2'(ROWS_PER_BLOCK - 1));
	assign pal_ready = !v_s3 || (feed && last_beat);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			row_q <= '0;
		end else begin
			if (pal_ready) v_s3 <= pal_valid;
			if (!v_s4 || rows.ready) v_s4 <= v_s3;
			// wraps to zero after the last row, ready for the next block
			if (feed) row_q <= row_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (pal_ready && pal_valid) pal_s3 <= pal;
	end

	// pick the four pixels of the current row
	assign row_idx   = pal_s3.indices[{row_q, 3'b000} +: 8];
	assign row_alpha = pal_s3.alphas[{row_q, 4'b0000} +: 16];

	always_comb begin
		for (int c = 0; c < 4; c++) begin
			// nibble*17 is the nibble repeated in both halves of the byte
			px[c] = {row_alpha[4*c +: 4], row_alpha[4*c +: 4],
				pal_s3.colour[row_idx[2*c +: 2]]};
		end
	end

	always_ff @(posedge clk) begin
		if (feed) begin
			row_s4  <= row_q;
			px_s4   <= px;
			last_s4 <= last_beat;
		end
	end

	assign rows.valid      = v_s4;
	assign rows.row_number = row_s4;
	assign rows.pixel_col0 = px_s4[0];
	assign rows.pixel_col1 = px_s4[1];
	assign rows.pixel_col2 = px_s4[2];
	assign rows.pixel_col3 = px_s4[3];
	assign rows.last_row   = last_s4;

	`DXT3_ASSERT_NEXT(a_block_held, feed && !last_beat, v_s3)
	`DXT3_ASSERT_NEXT(a_row_holds, v_s3 && !feed, $stable(row_q))
	`DXT3_ASSERT_NEXT(a_row_lands, feed, v_s4 && row_s4 == $past(row_q))
	`DXT3_ASSERT_NOW(a_idle_row_zero, !v_s3, row_q == 2'd0)

endmodule

`default_nettype wire

### sv/dxt3_block_decoder.sv
// BC2 (DXT3) block decoder. Each beat on blocks is one 16-byte block split into
// its alpha, endpoint and index fields; four beats leave on rows, one per pixel
// row from 0 to 3, each with four RGBA8 pixels (red in the low byte, alpha in
// the high byte) and last_row set on row 3. The row sequencer sends one row per
// cycle while rows is ready and takes the next block as the last row of the
// current one leaves; endpoint expansion and palette interpolation run in two
// pipeline stages ahead of it and hold a further two blocks. Rows of a block
// leave through the sequencer's palette register and then its output register.
// Both handshakes are valid/ready and either side may stall at any time.
`default_nettype none

module dxt3_block_decoder (
	input  wire logic  clk,
	input  wire logic  arst_n,
	dxt3_in_if.sink    blocks,
	dxt3_out_if.source rows
);
	import dxt3_pkg::*;

	logic pal_valid;
	logic pal_ready;
	pal_t pal;

	dxt3_palette u_palette (
		.clk       (clk),
		.arst_n    (arst_n),
		.blocks    (blocks),
		.pal_valid (pal_valid),
		.pal_ready (pal_ready),
		.pal       (pal)
	);

	dxt3_row_seq u_row_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.pal_valid (pal_valid),
		.pal_ready (pal_ready),
		.pal       (pal),
		.rows      (rows)
	);

endmodule

`default_nettype wire
